// ----- design/sctp_pkg.sv -----
// Shared constants, types and state codes of the skin conductance tonic/phasic core.
`default_nettype none
package sctp_pkg;

  // Default fixed point format of the filter levels
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned ADC_BITS_DEF  = 10;

  // Word field widths
  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned INV_W     = 10;
  localparam int unsigned PHASIC_W  = 17;
  localparam int unsigned TONIC_W   = 10;

  // Filter gains, Q0.16
  localparam int unsigned GAIN_W        = 16;
  localparam int unsigned FAST_GAIN_RST = 655;
  localparam int unsigned SLOW_GAIN_RST = 328;

  // Phasic scaling: difference over ten, remainder fits four bits
  localparam int unsigned PHASIC_DIV   = 10;
  localparam int unsigned PHASIC_REM_W = 4;

  // Tonic scaling to thousandths; quotient never reaches 2**TONIC_W
  localparam int unsigned TONIC_MUL = 1000;

  // APB port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  typedef enum logic {
    REG_FAST_GAIN = 1'b0,
    REG_SLOW_GAIN = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0] fast_gain;
    logic [GAIN_W-1:0] slow_gain;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FAST,
    ST_FSAVE,
    ST_SLOAD,
    ST_SLOW,
    ST_SSAVE,
    ST_PREP,
    ST_DIV
  } state_e;

endpackage
`default_nettype wire

// ----- design/sctp_if.sv -----
// Valid/ready channel interfaces for sample and result words.
`default_nettype none
interface sctp_in_if;
  logic                          valid;
  logic                          ready;
  logic [sctp_pkg::SAMPLE_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface sctp_out_if;
  logic                          valid;
  logic                          ready;
  logic [sctp_pkg::INV_W-1:0]    inverted_reading;
  logic [sctp_pkg::PHASIC_W-1:0] phasic_response;
  logic [sctp_pkg::TONIC_W-1:0]  tonic_level_milli;

  modport source (output valid, output inverted_reading, output phasic_response,
                  output tonic_level_milli, input ready);
  modport sink   (input valid, input inverted_reading, input phasic_response,
                  input tonic_level_milli, output ready);
endinterface
`default_nettype wire

// ----- design/sctp_regs.sv -----
// APB register file holding the two filter gains.
`default_nettype none
module sctp_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sctp_pkg::APB_AW-1:0]   paddr,
  input  wire logic [sctp_pkg::APB_DW-1:0]   pwdata,
  output logic      [sctp_pkg::APB_DW-1:0]   prdata,
  output logic                               pready,
  output sctp_pkg::cfg_t                     cfg_o
);

  sctp_pkg::cfg_t     cfg_q;
  sctp_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = sctp_pkg::reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fast_gain <= sctp_pkg::GAIN_W'(sctp_pkg::FAST_GAIN_RST);
      cfg_q.slow_gain <= sctp_pkg::GAIN_W'(sctp_pkg::SLOW_GAIN_RST);
    end else if (wr_en) begin
      unique case (idx)
        sctp_pkg::REG_FAST_GAIN: cfg_q.fast_gain <= pwdata[sctp_pkg::GAIN_W-1:0];
        sctp_pkg::REG_SLOW_GAIN: cfg_q.slow_gain <= pwdata[sctp_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sctp_pkg::REG_FAST_GAIN: prdata = sctp_pkg::APB_DW'(cfg_q.fast_gain);
      sctp_pkg::REG_SLOW_GAIN: prdata = sctp_pkg::APB_DW'(cfg_q.slow_gain);
      default:                 prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/sctp_mac.sv -----
// Serial-parallel one-pole filter update: one gain bit per cycle while step_i is high, LSB first.
`default_nettype none
module sctp_mac #(
  parameter int unsigned LVL_W = 26
) (
  input  wire logic                        clk_i,
  input  wire logic                        load_i,
  input  wire logic                        step_i,
  input  wire logic [sctp_pkg::GAIN_W-1:0] gain_i,
  input  wire logic [LVL_W-1:0]            target_i,
  input  wire logic [LVL_W-1:0]            level_i,
  output logic      [LVL_W-1:0]            level_o
);

  localparam int unsigned AccW = LVL_W + 2;

  logic signed [LVL_W:0]             diff_q;
  logic        [sctp_pkg::GAIN_W-1:0] gain_q;
  logic signed [AccW-1:0]            acc_q;
  logic signed [AccW-1:0]            addend;
  logic signed [AccW-1:0]            sum;
  logic signed [AccW-1:0]            lvl_sum;

  // level + floor(gain * (target - level) / 2**16); dropped LSBs give the floor
  assign addend  = gain_q[0] ? {diff_q[LVL_W], diff_q} : '0;
  assign sum     = acc_q + addend;
  assign lvl_sum = $signed({2'b00, level_i}) + acc_q;
  assign level_o = lvl_sum[LVL_W-1:0];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      diff_q <= $signed({1'b0, target_i}) - $signed({1'b0, level_i});
      gain_q <= gain_i;
      acc_q  <= '0;
    end else if (step_i) begin
      acc_q  <= sum >>> 1;
      gain_q <= gain_q >> 1;
    end
  end

endmodule
`default_nettype wire

// ----- design/sctp_div.sv -----
// Bit-serial restoring divider by a constant: one quotient bit per cycle while step_i is high, MSB first.
`default_nettype none
module sctp_div #(
  parameter int unsigned NUM_W = 26,
  parameter int unsigned REM_W = 4,
  parameter int unsigned DEN   = 10
) (
  input  wire logic             clk_i,
  input  wire logic             load_i,
  input  wire logic             step_i,
  input  wire logic [REM_W-1:0] rem_i,
  input  wire logic [NUM_W-1:0] num_i,
  output logic      [NUM_W-1:0] quo_o
);

  localparam logic [REM_W:0] DenV = (REM_W + 1)'(DEN);

  logic [REM_W-1:0] rem_q;
  logic [NUM_W-1:0] sr_q;
  logic [REM_W:0]   trial;
  logic [REM_W:0]   diff;
  logic             ge;

  // Dividend bits leave at the top while quotient bits enter at the bottom
  assign trial = {rem_q, sr_q[NUM_W-1]};
  assign ge    = trial >= DenV;
  assign diff  = trial - DenV;
  assign quo_o = sr_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= rem_i;
      sr_q  <= num_i;
    end else if (step_i) begin
      rem_q <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      sr_q  <= {sr_q[NUM_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// ----- design/skin_conductance_tonic_phasic_core.sv -----
// Skin conductance core: inversion, cascaded one-pole filters, phasic and tonic outputs.
// The word rate is set by the serial filter unit (16 gain bits per filter, two filters)
// and the bit-serial divide by ten.
// A sample is taken only while the core is idle; the result register frees the sample side.
// Reset (async, active low) clears both levels and restores the default gains.
`default_nettype none
module skin_conductance_tonic_phasic_core #(
  parameter int unsigned FRAC_BITS = sctp_pkg::FRAC_BITS_DEF,
  parameter int unsigned ADC_BITS  = sctp_pkg::ADC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  sctp_in_if.sink                            sample_i,
  sctp_out_if.source                         result_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sctp_pkg::APB_AW-1:0]   paddr,
  input  wire logic [sctp_pkg::APB_DW-1:0]   pwdata,
  output logic      [sctp_pkg::APB_DW-1:0]   prdata,
  output logic                               pready
);

  localparam int unsigned LW        = ADC_BITS + FRAC_BITS;
  localparam int unsigned CntW      = $clog2(LW + 1);
  localparam int unsigned PW        = LW + 2;
  localparam int unsigned TonW      = ADC_BITS + sctp_pkg::TONIC_W;
  localparam int unsigned AdcMax    = (1 << ADC_BITS) - 1;
  localparam int unsigned Offset    = (1 << FRAC_BITS) / 5;
  localparam int unsigned OneQ      = 1 << FRAC_BITS;
  localparam int unsigned UpShift   = (FRAC_BITS < 16) ? (16 - FRAC_BITS) : 0;
  localparam int unsigned DownShift = (FRAC_BITS >= 16) ? (FRAC_BITS - 16) : 0;
  localparam int unsigned ShW       = FRAC_BITS + 17;
  localparam logic [LW-1:0] LevelMax = {{ADC_BITS{1'b1}}, {FRAC_BITS{1'b0}}};

  sctp_pkg::cfg_t   cfg;
  sctp_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic [LW-1:0]       fast_q, slow_q;
  logic [ADC_BITS-1:0] inv_q;
  logic                neg_q;
  logic                out_valid_q;
  logic [sctp_pkg::INV_W-1:0]    out_inv_q;
  logic [sctp_pkg::PHASIC_W-1:0] out_phasic_q;
  logic [sctp_pkg::TONIC_W-1:0]  out_tonic_q;

  logic mac_load, mac_step, sel_slow, fast_we, slow_we;
  logic div_load, div_step, out_load, in_ready;

  logic [ADC_BITS-1:0]          inv_now;
  logic [sctp_pkg::GAIN_W-1:0]  mac_gain;
  logic [LW-1:0]                mac_target, mac_level, mac_out;
  logic                         d_neg;
  logic [LW-1:0]                mag;
  logic [TonW-1:0]              ton_num;
  logic [LW-1:0]                quo10;
  logic [sctp_pkg::TONIC_W-1:0] ton_quo;
  logic signed [PW-1:0]         p_pos, p_neg, p_raw;
  logic [FRAC_BITS:0]           p_clamp;
  logic [ShW-1:0]               p_shift;
  logic                         ton_step;

  sctp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign inv_now    = ~ADC_BITS'(sample_i.adc_sample);
  assign mac_gain   = sel_slow ? cfg.slow_gain : cfg.fast_gain;
  assign mac_target = sel_slow ? fast_q : {inv_now, {FRAC_BITS{1'b0}}};
  assign mac_level  = sel_slow ? slow_q : fast_q;

  sctp_mac #(.LVL_W(LW)) u_mac (
    .clk_i    (clk_i),
    .load_i   (mac_load),
    .step_i   (mac_step),
    .gain_i   (mac_gain),
    .target_i (mac_target),
    .level_i  (mac_level),
    .level_o  (mac_out)
  );

  // |fast - slow| feeds the divide by ten; sign is restored afterwards
  assign d_neg   = fast_q < slow_q;
  assign mag     = d_neg ? (slow_q - fast_q) : (fast_q - slow_q);
  assign ton_num = TonW'(fast_q[LW-1:FRAC_BITS]) * TonW'(sctp_pkg::TONIC_MUL);

  sctp_div #(
    .NUM_W (LW),
    .REM_W (sctp_pkg::PHASIC_REM_W),
    .DEN   (sctp_pkg::PHASIC_DIV)
  ) u_div_phasic (
    .clk_i  (clk_i),
    .load_i (div_load),
    .step_i (div_step),
    .rem_i  ('0),
    .num_i  (mag),
    .quo_o  (quo10)
  );

  // Upper dividend bits already sit below the divisor, so only the low bits iterate
  assign ton_step = div_step && (cnt_q < CntW'(sctp_pkg::TONIC_W));

  sctp_div #(
    .NUM_W (sctp_pkg::TONIC_W),
    .REM_W (ADC_BITS),
    .DEN   (AdcMax)
  ) u_div_tonic (
    .clk_i  (clk_i),
    .load_i (div_load),
    .step_i (ton_step),
    .rem_i  (ton_num[TonW-1:sctp_pkg::TONIC_W]),
    .num_i  (ton_num[sctp_pkg::TONIC_W-1:0]),
    .quo_o  (ton_quo)
  );

  // Offset plus or minus the quotient, clamped to 0..1, rescaled to 16 fraction bits
  assign p_pos = PW'(Offset) + $signed({2'b00, quo10});
  assign p_neg = PW'(Offset) - $signed({2'b00, quo10});
  assign p_raw = neg_q ? p_neg : p_pos;

  always_comb begin
    priority if (p_raw[PW-1]) begin
      p_clamp = '0;
    end else if (p_raw > $signed(PW'(OneQ))) begin
      p_clamp = (FRAC_BITS + 1)'(OneQ);
    end else begin
      p_clamp = p_raw[FRAC_BITS:0];
    end
  end

  assign p_shift = (ShW'(p_clamp) << UpShift) >> DownShift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sctp_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    mac_load = 1'b0;
    mac_step = 1'b0;
    sel_slow = 1'b0;
    fast_we  = 1'b0;
    slow_we  = 1'b0;
    div_load = 1'b0;
    div_step = 1'b0;
    out_load = 1'b0;
    in_ready = 1'b0;
    unique case (state_q)
      sctp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (sample_i.valid) begin
          mac_load = 1'b1;
          cnt_d    = '0;
          state_d  = sctp_pkg::ST_FAST;
        end
      end
      sctp_pkg::ST_FAST: begin
        mac_step = 1'b1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CntW'(sctp_pkg::GAIN_W - 1)) begin
          cnt_d   = '0;
          state_d = sctp_pkg::ST_FSAVE;
        end
      end
      sctp_pkg::ST_FSAVE: begin
        fast_we = 1'b1;
        state_d = sctp_pkg::ST_SLOAD;
      end
      sctp_pkg::ST_SLOAD: begin
        sel_slow = 1'b1;
        mac_load = 1'b1;
        state_d  = sctp_pkg::ST_SLOW;
      end
      sctp_pkg::ST_SLOW: begin
        sel_slow = 1'b1;
        mac_step = 1'b1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CntW'(sctp_pkg::GAIN_W - 1)) begin
          cnt_d   = '0;
          state_d = sctp_pkg::ST_SSAVE;
        end
      end
      sctp_pkg::ST_SSAVE: begin
        sel_slow = 1'b1;
        slow_we  = 1'b1;
        state_d  = sctp_pkg::ST_PREP;
      end
      sctp_pkg::ST_PREP: begin
        div_load = 1'b1;
        cnt_d    = '0;
        state_d  = sctp_pkg::ST_DIV;
      end
      sctp_pkg::ST_DIV: begin
        if (cnt_q == CntW'(LW)) begin
          // hold the finished word until the result register is free
          if (!out_valid_q || result_o.ready) begin
            out_load = 1'b1;
            cnt_d    = '0;
            state_d  = sctp_pkg::ST_IDLE;
          end
        end else begin
          div_step = 1'b1;
          cnt_d    = cnt_q + 1'b1;
        end
      end
      default: state_d = sctp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q      <= '0;
      slow_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fast_we) begin
        fast_q <= mac_out;
      end
      if (slow_we) begin
        slow_q <= mac_out;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mac_load && !sel_slow) begin
      inv_q <= inv_now;
    end
    if (div_load) begin
      neg_q <= d_neg;
    end
    if (out_load) begin
      out_inv_q    <= sctp_pkg::INV_W'(inv_q);
      out_phasic_q <= p_shift[sctp_pkg::PHASIC_W-1:0];
      out_tonic_q  <= ton_quo;
    end
  end

  assign sample_i.ready             = in_ready;
  assign result_o.valid             = out_valid_q;
  assign result_o.inverted_reading  = out_inv_q;
  assign result_o.phasic_response   = out_phasic_q;
  assign result_o.tonic_level_milli = out_tonic_q;

`ifndef NO_ASSERTIONS
  // An accepted sample starts the fast filter pass
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_i.valid && sample_i.ready |=> state_q == sctp_pkg::ST_FAST)
    else $error("accepted sample did not start the fast filter");

  // A finished word with a free result register lands there
  a_result_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sctp_pkg::ST_DIV && cnt_q == CntW'(LW) && (!out_valid_q || result_o.ready)
    |=> out_valid_q && state_q == sctp_pkg::ST_IDLE)
    else $error("finished word not moved to result register");

  // Filter levels never climb above full scale
  a_fast_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sctp_pkg::ST_FSAVE |=> fast_q <= LevelMax)
    else $error("fast level above full scale");

  a_slow_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sctp_pkg::ST_SSAVE |=> slow_q <= LevelMax)
    else $error("slow level above full scale");
`endif

endmodule
`default_nettype wire
